/* sv/solar_lamp_measure_sequencer_assert.svh */
// assertion macros for the solar lamp measure sequencer
// used by the top level; expects clk_i and rst_ni in scope
`ifndef SOLAR_LAMP_MEASURE_SEQUENCER_ASSERT_SVH
`define SOLAR_LAMP_MEASURE_SEQUENCER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SLMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// plain condition that must hold on every clock edge outside reset
`define SLMS_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

/* sv/slms_pkg.sv */
// shared types and constants for the solar lamp measure sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slms_pkg;

  // action codes carried on the input tuser
  localparam logic [1:0] ActTick    = 2'd0;
  localparam logic [1:0] ActStart   = 2'd1;
  localparam logic [1:0] ActSendOk  = 2'd2;
  localparam logic [1:0] ActSendBad = 2'd3;

  // bit positions in the pending step mask
  localparam int StepVolt   = 0;
  localparam int StepHtemp  = 1;
  localparam int StepHhum   = 2;
  localparam int StepLed    = 3;
  localparam int StepBtemp  = 4;
  localparam int StepBpress = 5;

  // led pattern lengths
  localparam logic [3:0] LenHumOk   = 4'd3;
  localparam logic [3:0] LenFail    = 4'd6;
  localparam logic [3:0] LenSendOk  = 4'd8;
  localparam logic [3:0] LenSendBad = 4'd14;

  // configuration register indexes
  localparam logic [2:0] RegRetryLimit = 3'd0;
  localparam logic [2:0] RegChargeOff  = 3'd1;
  localparam logic [2:0] RegChargeOn   = 3'd2;
  localparam logic [2:0] RegBatLow     = 3'd3;
  localparam logic [2:0] RegSolarDay   = 3'd4;
  localparam logic [2:0] RegSolarNight = 3'd5;

  // configuration reset values
  localparam logic [3:0]  RetryLimitRst  = 4'd10;
  localparam logic [11:0] ChargeOffRst   = 12'd3143;
  localparam logic [11:0] ChargeOnRst    = 12'd3128;
  localparam logic [11:0] BatLowRst      = 12'd2607;
  localparam logic [11:0] SolarDayRst    = 12'd62;
  localparam logic [11:0] SolarNightRst  = 12'd50;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindSteady = 2'd1,
    KindBlink  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [11:0] charge_off_level;
    logic [11:0] charge_on_level;
    logic [11:0] bat_low_level;
    logic [11:0] solar_day_level;
    logic [11:0] solar_night_level;
  } cfg_t;

  typedef struct packed {
    logic [5:0] pending_steps;
    logic [3:0] retry_left;
    kind_e      pattern_kind;
    logic [3:0] pattern_left;
    logic       indicator_level;
    logic       lamp_level;
    logic       charge_state;
    logic       low_latch;
  } state_t;

  // declared high to low so that lamp_on lands in bit 0
  typedef struct packed {
    logic busy_res;
    logic voltage_checked;
    logic baro_compute;
    logic start_baro_pressure;
    logic start_hygro_humidity;
    logic start_sensors;
    logic test_led;
    logic low_flag;
    logic charge_on;
    logic lamp_on;
  } result_t;

endpackage

`default_nettype wire

/* sv/solar_lamp_measure_sequencer.sv */
// solar lamp measure sequencer: state registers, result register, apb registers
// depends on slms_pkg, slms_step and solar_lamp_measure_sequencer_assert.svh
//
// usage:
//   input stream: tuser carries the action (tick, start, send ok, send failed),
//   tdata the converter readings and sensor status bits. every accepted transfer
//   gives exactly one result transfer on the output stream, carrying the lamp,
//   charger, low flag and led levels plus the single-item pulses and busy flag.
//   latency: the result is valid in the cycle after the input transfer.
//   throughput: one item per cycle while the receiver takes each result; the step
//   logic runs in a single pass between the sequencer state and the result
//   register, so a new transfer can follow at once.
//   stall: while the result register holds an untaken result and the receiver
//   keeps tready low, s_axis_tready is low; it rises in the cycle the receiver
//   takes the result, which then makes room for the next item.
//   reset: all sequencer state clears (lamp, charger, led off, nothing pending),
//   the output register empties and the apb registers return to their defaults.
//   registers: apb writes are taken at any time, reads return the stored value;
//   writes should only be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module solar_lamp_measure_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] battery_level, [23:12] solar_level, [24] hygro_temp_ready,
  // [25] hygro_hum_ready, [26] baro_temp_ok, [27] baro_press_ok, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] lamp_on, [1] charge_on, [2] low_flag, [3] test_led, [4] start_sensors,
  // [5] start_hygro_humidity, [6] start_baro_pressure, [7] baro_compute,
  // [8] voltage_checked, [9] busy_res, [15:10] zero
  output logic [15:0] m_axis_tdata
);

  slms_pkg::cfg_t    cfg_q;
  slms_pkg::state_t  state_q, state_d;
  slms_pkg::result_t res_q, res_d;
  logic              out_valid_q;
  logic              in_xfer, cfg_wr;
  logic [2:0]        reg_idx;
  logic              pending_any, led_busy, volt_busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit       <= slms_pkg::RetryLimitRst;
      cfg_q.charge_off_level  <= slms_pkg::ChargeOffRst;
      cfg_q.charge_on_level   <= slms_pkg::ChargeOnRst;
      cfg_q.bat_low_level     <= slms_pkg::BatLowRst;
      cfg_q.solar_day_level   <= slms_pkg::SolarDayRst;
      cfg_q.solar_night_level <= slms_pkg::SolarNightRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        slms_pkg::RegRetryLimit: cfg_q.retry_limit       <= pwdata[3:0];
        slms_pkg::RegChargeOff:  cfg_q.charge_off_level  <= pwdata[11:0];
        slms_pkg::RegChargeOn:   cfg_q.charge_on_level   <= pwdata[11:0];
        slms_pkg::RegBatLow:     cfg_q.bat_low_level     <= pwdata[11:0];
        slms_pkg::RegSolarDay:   cfg_q.solar_day_level   <= pwdata[11:0];
        slms_pkg::RegSolarNight: cfg_q.solar_night_level <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      slms_pkg::RegRetryLimit: prdata = {28'd0, cfg_q.retry_limit};
      slms_pkg::RegChargeOff:  prdata = {20'd0, cfg_q.charge_off_level};
      slms_pkg::RegChargeOn:   prdata = {20'd0, cfg_q.charge_on_level};
      slms_pkg::RegBatLow:     prdata = {20'd0, cfg_q.bat_low_level};
      slms_pkg::RegSolarDay:   prdata = {20'd0, cfg_q.solar_day_level};
      slms_pkg::RegSolarNight: prdata = {20'd0, cfg_q.solar_night_level};
      default:                 prdata = 32'd0;
    endcase
  end

  // room for a new item whenever the result register is empty or being drained
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  slms_step u_step (
    .state_i            (state_q),
    .cfg_i              (cfg_q),
    .action_i           (s_axis_tuser),
    .battery_level_i    (s_axis_tdata[11:0]),
    .solar_level_i      (s_axis_tdata[23:12]),
    .hygro_temp_ready_i (s_axis_tdata[24]),
    .hygro_hum_ready_i  (s_axis_tdata[25]),
    .baro_temp_ok_i     (s_axis_tdata[26]),
    .baro_press_ok_i    (s_axis_tdata[27]),
    .state_o            (state_d),
    .result_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q};

  assign pending_any = |state_q.pending_steps;
  assign led_busy    = state_q.pending_steps[slms_pkg::StepLed];
  assign volt_busy   = state_q.pending_steps[slms_pkg::StepVolt];

  `include "solar_lamp_measure_sequencer_assert.svh"

  // busy flag of a result mirrors the pending mask it leaves behind
  `SLMS_ASSERT(a_busy_pending, in_xfer |=> (res_q.busy_res == pending_any), "busy mismatch")
  // the led can only be lit while a pattern is running
  `SLMS_ASSERT_ALWAYS(a_led_pattern, led_busy || !state_q.indicator_level, "led lit while idle")
  // a voltage check pulse always retires the voltage step
  `SLMS_ASSERT(a_volt_retired, (in_xfer && res_d.voltage_checked) |=> !volt_busy, "volt pending")

endmodule

`default_nettype wire

/* sv/slms_step.sv */
// next-state and result logic for one item of the measure sequencer
// depends on slms_pkg
`timescale 1ns / 1ps
`default_nettype none

module slms_step (
  input  slms_pkg::state_t  state_i,
  input  slms_pkg::cfg_t    cfg_i,
  input  logic [1:0]        action_i,
  input  logic [11:0]       battery_level_i,
  input  logic [11:0]       solar_level_i,
  input  logic              hygro_temp_ready_i,
  input  logic              hygro_hum_ready_i,
  input  logic              baro_temp_ok_i,
  input  logic              baro_press_ok_i,
  output slms_pkg::state_t  state_o,
  output slms_pkg::result_t result_o
);

  function automatic slms_pkg::state_t pattern_begin(slms_pkg::state_t s_in,
                                                     slms_pkg::kind_e  kind,
                                                     logic [3:0]       len);
    slms_pkg::state_t s;
    s = s_in;
    if (!s.pending_steps[slms_pkg::StepLed]) begin
      s.pending_steps[slms_pkg::StepLed] = 1'b1;
      s.indicator_level = 1'b1;
      s.pattern_kind = kind;
      s.pattern_left = len;
    end
    return s;
  endfunction

  always_comb begin
    slms_pkg::state_t s;
    logic p_start, p_hum, p_press, p_comp, p_volt, done;
    s = state_i;
    p_start = 1'b0;
    p_hum = 1'b0;
    p_press = 1'b0;
    p_comp = 1'b0;
    p_volt = 1'b0;
    done = 1'b0;
    case (action_i)
      slms_pkg::ActStart: begin
        s.pending_steps[slms_pkg::StepHtemp] = 1'b1;
        s.pending_steps[slms_pkg::StepBtemp] = 1'b1;
        s.pending_steps[slms_pkg::StepVolt] = 1'b1;
        s.retry_left = cfg_i.retry_limit;
        p_start = 1'b1;
      end
      slms_pkg::ActSendOk: begin
        s = pattern_begin(s, slms_pkg::KindSteady, slms_pkg::LenSendOk);
      end
      slms_pkg::ActSendBad: begin
        s = pattern_begin(s, slms_pkg::KindBlink, slms_pkg::LenSendBad);
      end
      default: begin
        if (|s.pending_steps) begin
          // led pattern advances first
          if (s.pending_steps[slms_pkg::StepLed]) begin
            s.pattern_left = s.pattern_left - 4'd1;
            if (s.pattern_left == 4'd0) begin
              done = 1'b1;
            end else begin
              case (s.pattern_kind)
                slms_pkg::KindSteady: done = 1'b0;
                slms_pkg::KindBlink: begin
                  done = 1'b0;
                  if (!s.pattern_left[0]) s.indicator_level = ~s.indicator_level;
                end
                default: done = 1'b1;
              endcase
            end
            if (done) begin
              s.pending_steps[slms_pkg::StepLed] = 1'b0;
              s.indicator_level = 1'b0;
            end
          end
          // voltage check: charger hysteresis, low latch, lamp
          if (s.pending_steps[slms_pkg::StepVolt]) begin
            if (battery_level_i >= cfg_i.charge_off_level) begin
              s.charge_state = 1'b0;
            end else if (battery_level_i <= cfg_i.charge_on_level) begin
              s.charge_state = 1'b1;
            end
            if (battery_level_i <= cfg_i.bat_low_level) begin
              s.lamp_level = 1'b0;
              s.low_latch = 1'b1;
            end
            if (solar_level_i >= cfg_i.solar_day_level) begin
              s.lamp_level = 1'b0;
              s.low_latch = 1'b0;
            end else if (solar_level_i <= cfg_i.solar_night_level && !s.low_latch) begin
              s.lamp_level = 1'b1;
            end
            p_volt = 1'b1;
            s.pending_steps[slms_pkg::StepVolt] = 1'b0;
          end
          // humidity sensor temperature step
          if (s.pending_steps[slms_pkg::StepHtemp]) begin
            if (s.retry_left == 4'd0) begin
              s.pending_steps[slms_pkg::StepHtemp] = 1'b0;
              s = pattern_begin(s, slms_pkg::KindBlink, slms_pkg::LenFail);
            end else begin
              s.retry_left = s.retry_left - 4'd1;
              if (hygro_temp_ready_i) begin
                p_hum = 1'b1;
                s.pending_steps[slms_pkg::StepHtemp] = 1'b0;
                s.pending_steps[slms_pkg::StepHhum] = 1'b1;
                s.retry_left = cfg_i.retry_limit;
              end
            end
          end
          // humidity step, sampled in the tick it is entered
          if (s.pending_steps[slms_pkg::StepHhum]) begin
            if (s.retry_left == 4'd0) begin
              s.pending_steps[slms_pkg::StepHhum] = 1'b0;
              s = pattern_begin(s, slms_pkg::KindBlink, slms_pkg::LenFail);
            end else begin
              s.retry_left = s.retry_left - 4'd1;
              if (hygro_hum_ready_i) begin
                s.pending_steps[slms_pkg::StepHhum] = 1'b0;
                s = pattern_begin(s, slms_pkg::KindSteady, slms_pkg::LenHumOk);
              end
            end
          end
          // pressure sensor: temperature tick, then pressure tick
          if (s.pending_steps[slms_pkg::StepBtemp]) begin
            s.pending_steps[slms_pkg::StepBtemp] = 1'b0;
            if (baro_temp_ok_i) begin
              p_press = 1'b1;
              s.pending_steps[slms_pkg::StepBpress] = 1'b1;
            end
          end else if (s.pending_steps[slms_pkg::StepBpress]) begin
            s.pending_steps[slms_pkg::StepBpress] = 1'b0;
            p_comp = baro_press_ok_i;
          end
        end
      end
    endcase

    state_o = s;
    result_o.lamp_on = s.lamp_level;
    result_o.charge_on = s.charge_state;
    result_o.low_flag = s.low_latch;
    result_o.test_led = s.indicator_level;
    result_o.start_sensors = p_start;
    result_o.start_hygro_humidity = p_hum;
    result_o.start_baro_pressure = p_press;
    result_o.baro_compute = p_comp;
    result_o.voltage_checked = p_volt;
    result_o.busy_res = |s.pending_steps;
  end

endmodule

`default_nettype wire
